### hw/rtl/cscan_disk_request_scheduler_macros.svh
// ----------------------------------------------------------------------------
// cscan_disk_request_scheduler_macros.svh
// Assertion macros for the C-SCAN request scheduler. With SYNTH defined
// they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef CSCAN_DISK_REQUEST_SCHEDULER_MACROS_SVH
`define CSCAN_DISK_REQUEST_SCHEDULER_MACROS_SVH

`ifndef SYNTH
// property checked at every rising clock edge, off while reset is held
`define CDRS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// same, on the default clock and reset names of the block
`define CDRS_ASSERT(label, prop, msg) \
  `CDRS_ASSERT_CLK(label, clk, rst_n, prop, msg)
`else
`define CDRS_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define CDRS_ASSERT(label, prop, msg)
`endif

`endif

### hw/rtl/cdrs_pkg.sv
// ----------------------------------------------------------------------------
// cdrs_pkg
// Shared types and constants of the C-SCAN request scheduler.
// ----------------------------------------------------------------------------
package cdrs_pkg;

  // command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_SERVE = 1'b1;

  // reset values, truncated to the configured widths where used
  localparam logic [63:0] HEAD_RESET        = 64'd500;
  localparam logic [63:0] BLOCK_COUNT_RESET = 64'd1000;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } cdrs_status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } cdrs_state_t;

  // controls into the scan tracker
  typedef struct packed {
    logic clear;
    logic load;
  } cdrs_scan_ctl_t;

  // flags out of the scan tracker
  typedef struct packed {
    logic any;
    logic above;
  } cdrs_scan_flags_t;

endpackage

### hw/rtl/cscan_disk_request_scheduler.sv
// ----------------------------------------------------------------------------
// cscan_disk_request_scheduler
// C-SCAN disk request scheduler: a table of pending block numbers in a
// synchronous memory, filled by add words and drained by serve words.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+--------------------------
//   in_      | input     | in_valid / in_stall    | cmd, block
//   out_     | output    | out_valid / out_stall  | status, served_block,
//            |           |                        | seek_distance, wrapped,
//            |           |                        | pending_count
//   cfg_     | input     | cfg_wr_en              | block_count
//
// An add word's result is loaded at the accept edge. A serve word makes one
// memory read per table slot, waits for the registered read data of the
// last slot, then finishes in S_FIN and loads its result. Reset clears the
// valid bits and the count and loads the head reset value at once; no
// clearing pass. in_stall is high while a serve is in progress and while a
// result is held by out_stall; a held result stays in the output register.
// ----------------------------------------------------------------------------
`include "cscan_disk_request_scheduler_macros.svh"

module cscan_disk_request_scheduler
  import cdrs_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int BLOCK_BITS  = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_wr_en,
  input  logic [BLOCK_BITS:0]              cfg_wr_data,
  // request words
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_cmd,
  input  logic [BLOCK_BITS-1:0]            in_block,
  // result words
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_status,
  output logic [BLOCK_BITS-1:0]            out_served_block,
  output logic [BLOCK_BITS:0]              out_seek_distance,
  output logic                             out_wrapped,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] out_pending_count
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  cdrs_state_t state_r, state_nxt;

  logic [BLOCK_BITS:0]    block_count_r;
  logic [BLOCK_BITS-1:0]  head_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [CW-1:0]          count_r;

  // pending block table
  logic [BLOCK_BITS-1:0]  mem [TABLE_DEPTH];
  logic [BLOCK_BITS-1:0]  rdata_r;
  logic [IW-1:0]          scan_idx_r;
  logic                   issue_done_r;
  logic                   tag_vld_r;
  logic [IW-1:0]          tag_idx_r;

  // output register
  logic                   out_valid_r;
  cdrs_status_t           status_r;
  logic [BLOCK_BITS-1:0]  served_r;
  logic [BLOCK_BITS:0]    dist_r;
  logic                   wrapped_r;
  logic [CW-1:0]          pcount_r;

  logic                   accept;
  logic                   is_add;
  logic                   out_range;
  logic                   has_free;
  logic [IW-1:0]          free_idx;
  logic                   add_ok;
  logic                   mem_wr;
  logic                   res_load;

  cdrs_scan_ctl_t         scan_ctl;
  cdrs_scan_flags_t       scan_flags;
  logic [BLOCK_BITS-1:0]  min_all, min_above, target;
  logic [TABLE_DEPTH-1:0] mask_all, mask_above, rm_mask;
  logic [CW-1:0]          cnt_all, cnt_above, rm_cnt;
  logic [BLOCK_BITS:0]    fin_dist;

  // input handshake
  assign in_stall = (state_r != S_IDLE) | (out_valid_r & out_stall);
  assign accept   = in_valid & ~in_stall;
  assign is_add   = (in_cmd == CMD_ADD);

  // add checks: range first, then lowest free slot
  assign out_range = {1'b0, in_block} >= block_count_r;
  assign has_free  = ~&valid_r;

  always_comb begin
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  assign add_ok = ~out_range & has_free;
  assign mem_wr = (state_r == S_IDLE) & accept & is_add & add_ok;

  // result register load: add at accept, serve at finish
  assign res_load = ((state_r == S_IDLE) & accept & is_add) | (state_r == S_FIN);

  // scan tracker
  assign scan_ctl.clear = (state_r == S_IDLE) & accept & ~is_add;
  assign scan_ctl.load  = (state_r == S_SCAN) & tag_vld_r & valid_r[tag_idx_r];

  cdrs_scan #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .BLOCK_BITS  (BLOCK_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .elem_idx   (tag_idx_r),
    .elem_val   (rdata_r),
    .head       (head_r),
    .flags      (scan_flags),
    .min_all    (min_all),
    .min_above  (min_above),
    .mask_all   (mask_all),
    .mask_above (mask_above),
    .cnt_all    (cnt_all),
    .cnt_above  (cnt_above)
  );

  // choice of target and seek distance
  assign target  = scan_flags.above ? min_above  : min_all;
  assign rm_mask = scan_flags.above ? mask_above : mask_all;
  assign rm_cnt  = scan_flags.above ? cnt_above  : cnt_all;
  assign fin_dist = scan_flags.above ?
                    ({1'b0, target} - {1'b0, head_r}) :
                    (block_count_r - {1'b0, head_r} + {1'b0, target});

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && !is_add) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tag_vld_r && tag_idx_r == LAST_IDX) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      block_count_r <= BLOCK_COUNT_RESET[BLOCK_BITS:0];
      head_r        <= HEAD_RESET[BLOCK_BITS-1:0];
      valid_r       <= '0;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
      scan_idx_r    <= '0;
      issue_done_r  <= 1'b0;
      tag_vld_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        block_count_r <= cfg_wr_data;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (is_add) begin
              if (add_ok) begin
                valid_r[free_idx] <= 1'b1;
                count_r           <= count_r + CW'(1);
              end
            end else begin
              scan_idx_r   <= '0;
              issue_done_r <= 1'b0;
              tag_vld_r    <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          tag_vld_r <= ~issue_done_r;
          if (!issue_done_r) begin
            if (scan_idx_r == LAST_IDX) begin
              issue_done_r <= 1'b1;
            end else begin
              scan_idx_r <= scan_idx_r + IW'(1);
            end
          end
        end
        S_FIN: begin
          if (scan_flags.any) begin
            valid_r <= valid_r & ~rm_mask;
            count_r <= count_r - rm_cnt;
            head_r  <= target;
          end
        end
        default: begin
          tag_vld_r <= 1'b0;
        end
      endcase
    end
  end

  // table memory: one write port for adds, one registered read for scans
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[free_idx] <= in_block;
    end
    rdata_r   <= mem[scan_idx_r];
    tag_idx_r <= scan_idx_r;
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept && is_add) begin
      served_r  <= '0;
      dist_r    <= '0;
      wrapped_r <= 1'b0;
      if (out_range) begin
        status_r <= ST_RANGE;
        pcount_r <= count_r;
      end else if (!has_free) begin
        status_r <= ST_FULL;
        pcount_r <= count_r;
      end else begin
        status_r <= ST_OK;
        pcount_r <= count_r + CW'(1);
      end
    end else if (state_r == S_FIN) begin
      if (scan_flags.any) begin
        status_r  <= ST_OK;
        served_r  <= target;
        dist_r    <= fin_dist;
        wrapped_r <= ~scan_flags.above;
        pcount_r  <= count_r - rm_cnt;
      end else begin
        status_r  <= ST_EMPTY;
        served_r  <= '0;
        dist_r    <= '0;
        wrapped_r <= 1'b0;
        pcount_r  <= count_r;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_served_block  = served_r;
  assign out_seek_distance = dist_r;
  assign out_wrapped       = wrapped_r;
  assign out_pending_count = pcount_r;

  // checks
  `CDRS_ASSERT(a_count_matches_valid, count_r == CW'($countones(valid_r)), "pending count differs from valid bits")
  `CDRS_ASSERT(a_fin_loads_result, state_r == S_FIN |=> out_valid_r, "finished serve produced no result")
  `CDRS_ASSERT(a_head_follows_serve, (state_r == S_FIN && scan_flags.any) |=> out_served_block == head_r, "head not moved to served block")

endmodule

### hw/rtl/cdrs_scan.sv
// ----------------------------------------------------------------------------
// cdrs_scan
// Running minimum tracker for one table scan: keeps the smallest pending
// block overall and the smallest strictly above the head, with the mask and
// count of slots that hold each.
// ----------------------------------------------------------------------------
module cdrs_scan
  import cdrs_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int BLOCK_BITS  = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cdrs_scan_ctl_t                       ctl,
  input  logic [$clog2(TABLE_DEPTH)-1:0]       elem_idx,
  input  logic [BLOCK_BITS-1:0]                elem_val,
  input  logic [BLOCK_BITS-1:0]                head,
  output cdrs_scan_flags_t                     flags,
  output logic [BLOCK_BITS-1:0]                min_all,
  output logic [BLOCK_BITS-1:0]                min_above,
  output logic [TABLE_DEPTH-1:0]               mask_all,
  output logic [TABLE_DEPTH-1:0]               mask_above,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     cnt_all,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     cnt_above
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [TABLE_DEPTH-1:0] ONE = {{(TABLE_DEPTH-1){1'b0}}, 1'b1};

  logic                   any_r, above_r;
  logic [BLOCK_BITS-1:0]  min_all_r, min_above_r;
  logic [TABLE_DEPTH-1:0] mask_all_r, mask_above_r;
  logic [CW-1:0]          cnt_all_r, cnt_above_r;
  logic [TABLE_DEPTH-1:0] elem_bit;
  logic                   is_above;

  assign elem_bit = ONE << elem_idx;
  assign is_above = elem_val > head;

  // found flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r   <= 1'b0;
      above_r <= 1'b0;
    end else if (ctl.clear) begin
      any_r   <= 1'b0;
      above_r <= 1'b0;
    end else if (ctl.load) begin
      any_r <= 1'b1;
      if (is_above) begin
        above_r <= 1'b1;
      end
    end
  end

  // running minima with their slot masks and counts
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (!any_r || elem_val < min_all_r) begin
        min_all_r  <= elem_val;
        mask_all_r <= elem_bit;
        cnt_all_r  <= CW'(1);
      end else if (elem_val == min_all_r) begin
        mask_all_r <= mask_all_r | elem_bit;
        cnt_all_r  <= cnt_all_r + CW'(1);
      end
      if (is_above) begin
        if (!above_r || elem_val < min_above_r) begin
          min_above_r  <= elem_val;
          mask_above_r <= elem_bit;
          cnt_above_r  <= CW'(1);
        end else if (elem_val == min_above_r) begin
          mask_above_r <= mask_above_r | elem_bit;
          cnt_above_r  <= cnt_above_r + CW'(1);
        end
      end
    end
  end

  assign flags.any   = any_r;
  assign flags.above = above_r;
  assign min_all     = min_all_r;
  assign min_above   = min_above_r;
  assign mask_all    = mask_all_r;
  assign mask_above  = mask_above_r;
  assign cnt_all     = cnt_all_r;
  assign cnt_above   = cnt_above_r;

endmodule
